[src/vector_path_command_resolver_macros.svh]
// Assertion macros used by the checker file of the path command resolver.
`ifndef VECTOR_PATH_COMMAND_RESOLVER_MACROS_SVH
`define VECTOR_PATH_COMMAND_RESOLVER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VPCR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define VPCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Implication that also samples during reset.
`define VPCR_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error(msg);

`endif

[src/vpcr_pkg.sv]
// Shared types, codes and widths of the vector path command resolver.
`default_nettype none

package vpcr_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int FIELD_WIDTH = 32;

   localparam int IN_DATA_WIDTH = 232;
   localparam int IN_USER_WIDTH = 5;
   localparam int OUT_DATA_WIDTH = 232;
   localparam int OUT_USER_WIDTH = 3;

   localparam int RSP_DEPTH = 4;

   localparam logic [3:0] CMD_REPEAT = 4'd0;
   localparam logic [3:0] CMD_MOVE = 4'd1;
   localparam logic [3:0] CMD_LINE = 4'd2;
   localparam logic [3:0] CMD_HORIZ = 4'd3;
   localparam logic [3:0] CMD_VERT = 4'd4;
   localparam logic [3:0] CMD_CUBIC = 4'd5;
   localparam logic [3:0] CMD_SMOOTH = 4'd6;
   localparam logic [3:0] CMD_ARC = 4'd7;
   localparam logic [3:0] CMD_CLOSE = 4'd8;
   localparam logic [3:0] CMD_END = 4'd9;
   localparam logic [3:0] CMD_UNKNOWN = 4'd10;

   localparam logic [2:0] KIND_BEGIN = 3'd0;
   localparam logic [2:0] KIND_LINE = 3'd1;
   localparam logic [2:0] KIND_CUBIC = 3'd2;
   localparam logic [2:0] KIND_ARC = 3'd3;
   localparam logic [2:0] KIND_END_OPEN = 3'd4;
   localparam logic [2:0] KIND_END_CLOSED = 3'd5;
   localparam logic [2:0] KIND_DONE = 3'd6;

   typedef struct packed {
      logic [3:0] command;
      logic relative;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] rotation;
      logic large_arc;
      logic sweep;
   } item_type;

   typedef struct packed {
      logic [2:0] kind;
      logic signed [31:0] pt_x;
      logic signed [31:0] pt_y;
      logic signed [31:0] ctl1_x;
      logic signed [31:0] ctl1_y;
      logic signed [31:0] ctl2_x;
      logic signed [31:0] ctl2_y;
      logic signed [31:0] arc_angle;
      logic arc_large;
      logic arc_clockwise;
      logic last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } result_pair_type;

endpackage

`default_nettype wire

[src/vpcr_resolver.sv]
// Path state registers and the single-pass command resolution logic.
`default_nettype none

module vpcr_resolver #(
   parameter int COORD_WIDTH = vpcr_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic fire,
   input  wire vpcr_pkg::item_type item,
   output vpcr_pkg::result_pair_type results
);

   localparam int SW = (COORD_WIDTH >= 32) ? 32 : COORD_WIDTH;
   localparam logic signed [33:0] SAT_HI = (34'sd1 <<< (SW - 1)) - 34'sd1;
   localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;

   logic signed [SW-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [SW-1:0] fig_x_ff, fig_x_in, fig_y_ff, fig_y_in;
   logic signed [SW-1:0] ctl_x_ff, ctl_x_in, ctl_y_ff, ctl_y_in;
   logic open_ff, open_in;
   logic [3:0] prev_cmd_ff, prev_cmd_in;
   logic prev_rel_ff, prev_rel_in;
   logic was_cubic_ff, was_cubic_in;
   logic halted_ff, halted_in;

   function automatic logic signed [SW-1:0] sat(input logic signed [33:0] v);
      if (v > SAT_HI) begin
         return SAT_HI[SW-1:0];
      end else if (v < SAT_LO) begin
         return SAT_LO[SW-1:0];
      end
      return v[SW-1:0];
   endfunction

   function automatic logic signed [SW-1:0] place(input logic rel,
                                                   input logic signed [31:0] base,
                                                   input logic signed [31:0] v);
      logic signed [33:0] s;
      s = rel ? (34'(base) + 34'(v)) : 34'(v);
      return sat(s);
   endfunction

   logic [3:0] cmd;
   logic rel;
   logic signed [31:0] cx, cy;
   logic signed [SW-1:0] px, py, c1x, c1y, c2x, c2y, rx, ry;
   logic signed [33:0] ax_wide, ay_wide;
   logic clear;
   vpcr_pkg::result_type r0, r1;
   logic [1:0] n;

   assign cx = 32'(cur_x_ff);
   assign cy = 32'(cur_y_ff);
   assign ax_wide = 34'(item.a_x);
   assign ay_wide = 34'(item.a_y);

   always_comb begin
      // resolve a repeat to the previous command, a move turning into a line
      cmd = item.command;
      rel = item.relative;
      if (item.command == vpcr_pkg::CMD_REPEAT) begin
         cmd = (prev_cmd_ff == vpcr_pkg::CMD_MOVE) ? vpcr_pkg::CMD_LINE : prev_cmd_ff;
         rel = prev_rel_ff;
         if (cmd == vpcr_pkg::CMD_REPEAT) begin
            cmd = vpcr_pkg::CMD_UNKNOWN;
         end
      end
   end

   always_comb begin
      px = place(rel, cx, item.end_x);
      py = place(rel, cy, item.end_y);
      c2x = place(rel, cx, item.b_x);
      c2y = place(rel, cy, item.b_y);
      rx = sat(ax_wide[33] ? -ax_wide : ax_wide);
      ry = sat(ay_wide[33] ? -ay_wide : ay_wide);
      if (cmd == vpcr_pkg::CMD_CUBIC) begin
         c1x = place(rel, cx, item.a_x);
         c1y = place(rel, cy, item.a_y);
      end else if (was_cubic_ff) begin
         // mirror the last control point about the current point
         c1x = sat((34'(cx) <<< 1) - 34'(ctl_x_ff));
         c1y = sat((34'(cy) <<< 1) - 34'(ctl_y_ff));
      end else begin
         c1x = cur_x_ff;
         c1y = cur_y_ff;
      end
   end

   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      fig_x_in = fig_x_ff;
      fig_y_in = fig_y_ff;
      ctl_x_in = ctl_x_ff;
      ctl_y_in = ctl_y_ff;
      open_in = open_ff;
      prev_cmd_in = prev_cmd_ff;
      prev_rel_in = prev_rel_ff;
      was_cubic_in = was_cubic_ff;
      halted_in = halted_ff;
      clear = 1'b0;
      r0 = '0;
      r1 = '0;
      n = 2'd0;

      if (halted_ff) begin
         clear = (item.command == vpcr_pkg::CMD_END);
      end else begin
         prev_cmd_in = cmd;
         prev_rel_in = rel;
         was_cubic_in = (cmd == vpcr_pkg::CMD_CUBIC) || (cmd == vpcr_pkg::CMD_SMOOTH);
         case (cmd) inside
            vpcr_pkg::CMD_MOVE: begin
               cur_x_in = px;
               cur_y_in = py;
               fig_x_in = px;
               fig_y_in = py;
               open_in = 1'b1;
               if (open_ff) begin
                  r0.kind = vpcr_pkg::KIND_END_OPEN;
                  r1.kind = vpcr_pkg::KIND_BEGIN;
                  r1.pt_x = 32'(px);
                  r1.pt_y = 32'(py);
                  n = 2'd2;
               end else begin
                  r0.kind = vpcr_pkg::KIND_BEGIN;
                  r0.pt_x = 32'(px);
                  r0.pt_y = 32'(py);
                  n = 2'd1;
               end
            end
            vpcr_pkg::CMD_LINE, vpcr_pkg::CMD_HORIZ, vpcr_pkg::CMD_VERT: begin
               if (cmd != vpcr_pkg::CMD_VERT) begin
                  cur_x_in = px;
               end
               if (cmd != vpcr_pkg::CMD_HORIZ) begin
                  cur_y_in = py;
               end
               r0.kind = vpcr_pkg::KIND_LINE;
               r0.pt_x = 32'(cur_x_in);
               r0.pt_y = 32'(cur_y_in);
               n = 2'd1;
            end
            vpcr_pkg::CMD_CUBIC, vpcr_pkg::CMD_SMOOTH: begin
               cur_x_in = px;
               cur_y_in = py;
               ctl_x_in = c2x;
               ctl_y_in = c2y;
               r0.kind = vpcr_pkg::KIND_CUBIC;
               r0.pt_x = 32'(px);
               r0.pt_y = 32'(py);
               r0.ctl1_x = 32'(c1x);
               r0.ctl1_y = 32'(c1y);
               r0.ctl2_x = 32'(c2x);
               r0.ctl2_y = 32'(c2y);
               n = 2'd1;
            end
            vpcr_pkg::CMD_ARC: begin
               cur_x_in = px;
               cur_y_in = py;
               r0.kind = vpcr_pkg::KIND_ARC;
               r0.pt_x = 32'(px);
               r0.pt_y = 32'(py);
               r0.ctl1_x = 32'(rx);
               r0.ctl1_y = 32'(ry);
               r0.arc_angle = item.rotation;
               r0.arc_large = item.large_arc;
               r0.arc_clockwise = item.sweep;
               n = 2'd1;
            end
            vpcr_pkg::CMD_CLOSE: begin
               cur_x_in = fig_x_ff;
               cur_y_in = fig_y_ff;
               open_in = 1'b0;
               if (open_ff) begin
                  r0.kind = vpcr_pkg::KIND_END_CLOSED;
                  n = 2'd1;
               end
            end
            vpcr_pkg::CMD_END: begin
               clear = 1'b1;
               if (open_ff) begin
                  r0.kind = vpcr_pkg::KIND_END_CLOSED;
                  r1.kind = vpcr_pkg::KIND_DONE;
                  n = 2'd2;
               end else begin
                  r0.kind = vpcr_pkg::KIND_DONE;
                  n = 2'd1;
               end
            end
            default: begin
               // unknown command: end the figure open, finish, then drop until end
               prev_cmd_in = prev_cmd_ff;
               prev_rel_in = prev_rel_ff;
               was_cubic_in = was_cubic_ff;
               open_in = 1'b0;
               halted_in = 1'b1;
               if (open_ff) begin
                  r0.kind = vpcr_pkg::KIND_END_OPEN;
                  r1.kind = vpcr_pkg::KIND_DONE;
                  n = 2'd2;
               end else begin
                  r0.kind = vpcr_pkg::KIND_DONE;
                  n = 2'd1;
               end
            end
         endcase
      end

      if (n == 2'd2) begin
         r1.last = 1'b1;
      end else if (n == 2'd1) begin
         r0.last = 1'b1;
      end

      if (clear) begin
         cur_x_in = '0;
         cur_y_in = '0;
         fig_x_in = '0;
         fig_y_in = '0;
         ctl_x_in = '0;
         ctl_y_in = '0;
         open_in = 1'b0;
         prev_cmd_in = vpcr_pkg::CMD_REPEAT;
         prev_rel_in = 1'b0;
         was_cubic_in = 1'b0;
         halted_in = 1'b0;
      end
   end

   assign results.count = n;
   assign results.first = r0;
   assign results.second = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         fig_x_ff <= '0;
         fig_y_ff <= '0;
         ctl_x_ff <= '0;
         ctl_y_ff <= '0;
         open_ff <= 1'b0;
         prev_cmd_ff <= vpcr_pkg::CMD_REPEAT;
         prev_rel_ff <= 1'b0;
         was_cubic_ff <= 1'b0;
         halted_ff <= 1'b0;
      end else if (fire) begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         fig_x_ff <= fig_x_in;
         fig_y_ff <= fig_y_in;
         ctl_x_ff <= ctl_x_in;
         ctl_y_ff <= ctl_y_in;
         open_ff <= open_in;
         prev_cmd_ff <= prev_cmd_in;
         prev_rel_ff <= prev_rel_in;
         was_cubic_ff <= was_cubic_in;
         halted_ff <= halted_in;
      end
   end

endmodule

`default_nettype wire

[src/vpcr_rsp_fifo.sv]
// Small result queue that takes up to two results a cycle and gives one.
`default_nettype none

module vpcr_rsp_fifo (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  wire vpcr_pkg::result_pair_type pair,
   input  wire logic pop,
   output logic room,
   output logic head_valid,
   output vpcr_pkg::result_type head
);

   localparam int DEPTH = vpcr_pkg::RSP_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   vpcr_pkg::result_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [1:0] push_n;
   logic do_pop;

   assign push_n = push ? pair.count : 2'd0;
   assign do_pop = pop && head_valid;
   assign head_valid = (fill_ff != '0);
   assign head = slots_ff[rd_ptr_ff];
   // room for a full pair, ignoring a pop in the same cycle
   assign room = (fill_ff <= CNT_W'(DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + PTR_W'(do_pop);
      fill_in = fill_ff + CNT_W'(push_n) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         slots_ff[wr_ptr_ff] <= pair.first;
      end
      if (push_n == 2'd2) begin
         slots_ff[wr_ptr_ff + PTR_W'(1)] <= pair.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

[src/vector_path_command_resolver.sv]
// A request is held in the input register, resolved and pushed into the result queue when it
// fires, and offered on the result port from the head of the queue.
// Throughput: one request per cycle while the queue has room; a request that gives two results
// offers them one after another, set by the single result port draining a four-entry result queue.
// A request waits in the input register while the queue lacks room for two results.
// Reset is synchronous, active high: path state, input valid flag and queue clear at once.
`default_nettype none

module vector_path_command_resolver #(
   parameter int COORD_WIDTH = vpcr_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   // a_x, a_y, b_x, b_y, end_x, end_y, rotation, large_arc, sweep, zero pad
   input  wire logic [vpcr_pkg::IN_DATA_WIDTH-1:0] req_tdata,
   // command, relative
   input  wire logic [vpcr_pkg::IN_USER_WIDTH-1:0] req_tuser,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // pt_x, pt_y, ctl1_x, ctl1_y, ctl2_x, ctl2_y, arc_angle, arc_large, arc_clockwise, zero pad
   output logic [vpcr_pkg::OUT_DATA_WIDTH-1:0] rsp_tdata,
   // kind
   output logic [vpcr_pkg::OUT_USER_WIDTH-1:0] rsp_tuser,
   output logic rsp_tlast
);

   vpcr_pkg::item_type item_ff, item_in;
   logic valid_ff;
   logic room, fire, accept;
   vpcr_pkg::result_pair_type pair;
   vpcr_pkg::result_type head;

   assign fire = valid_ff && room;
   assign req_tready = !valid_ff || room;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      item_in.command = req_tuser[3:0];
      item_in.relative = req_tuser[4];
      item_in.a_x = req_tdata[31:0];
      item_in.a_y = req_tdata[63:32];
      item_in.b_x = req_tdata[95:64];
      item_in.b_y = req_tdata[127:96];
      item_in.end_x = req_tdata[159:128];
      item_in.end_y = req_tdata[191:160];
      item_in.rotation = req_tdata[223:192];
      item_in.large_arc = req_tdata[224];
      item_in.sweep = req_tdata[225];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (fire) begin
         valid_ff <= 1'b0;
      end
   end

   vpcr_resolver #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_resolver (
      .clock(clock),
      .reset(reset),
      .fire(fire),
      .item(item_ff),
      .results(pair)
   );

   vpcr_rsp_fifo u_rsp_fifo (
      .clock(clock),
      .reset(reset),
      .push(fire),
      .pair(pair),
      .pop(rsp_tready),
      .room(room),
      .head_valid(rsp_tvalid),
      .head(head)
   );

   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;
   assign rsp_tdata = {6'b0, head.arc_clockwise, head.arc_large, head.arc_angle,
                       head.ctl2_y, head.ctl2_x, head.ctl1_y, head.ctl1_x,
                       head.pt_y, head.pt_x};

endmodule

`default_nettype wire

[src/vpcr_checker.sv]
// Port-level checks on the result stream of the path command resolver, with its bind.
`default_nettype none
`include "vector_path_command_resolver_macros.svh"

module vpcr_port_checks (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [vpcr_pkg::OUT_DATA_WIDTH-1:0] rsp_tdata,
   input wire logic [vpcr_pkg::OUT_USER_WIDTH-1:0] rsp_tuser,
   input wire logic rsp_tlast
);

   logic marker;
   logic stalled, marker_shown, done_shown, open_shown;

   assign marker = (rsp_tuser == vpcr_pkg::KIND_END_OPEN) ||
                   (rsp_tuser == vpcr_pkg::KIND_END_CLOSED) ||
                   (rsp_tuser == vpcr_pkg::KIND_DONE);
   assign stalled = rsp_tvalid && !rsp_tready;
   assign marker_shown = rsp_tvalid && marker;
   assign done_shown = rsp_tvalid && (rsp_tuser == vpcr_pkg::KIND_DONE);
   assign open_shown = rsp_tvalid && (rsp_tuser == vpcr_pkg::KIND_END_OPEN);

   `VPCR_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_tvalid, "result dropped while stalled")
   `VPCR_ASSERT_IMPLY(a_marker_zero, clock, reset, marker_shown, rsp_tdata == '0, "marker has data")
   `VPCR_ASSERT_IMPLY(a_done_last, clock, reset, done_shown, rsp_tlast, "path done without last")
   `VPCR_ASSERT_IMPLY(a_open_not_last, clock, reset, open_shown, !rsp_tlast, "end open marked last")
   `VPCR_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset), !rsp_tvalid, "result shown after reset")

endmodule

bind vector_path_command_resolver vpcr_port_checks u_vpcr_port_checks (
   .clock(clock),
   .reset(reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser),
   .rsp_tlast(rsp_tlast)
);

`default_nettype wire
